FILE: src/dnsrt_pkg.sv
// Shared types, codes and defaults for the DNS relay pending table.
// Used by dnsrt_cfg_regs, dnsrt_slot_store and dns_relay_pending_table_unit.
package dnsrt_pkg;

    localparam int SLOTS_DEF = 32;

    localparam int ADDR_W = 5;
    localparam int CFG_IDX_W = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] REG_PROXY_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECONDARY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEND_TMO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAILOVR_TMO = 3'd4;

    localparam logic [31:0] TIMEOUT_RST = 32'd1000;

    // item kinds
    localparam logic [1:0] KIND_QUERY    = 2'd0;
    localparam logic [1:0] KIND_RESPONSE = 2'd1;
    localparam logic [1:0] KIND_CHECK    = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_FORWARDED  = 3'd0;
    localparam logic [2:0] ST_SERVFAIL   = 3'd1;
    localparam logic [2:0] ST_DISABLED   = 3'd2;
    localparam logic [2:0] ST_MATCHED    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_SWITCHED   = 3'd5;
    localparam logic [2:0] ST_NO_SWITCH  = 3'd6;

    localparam logic [15:0] UPORT_FLAG = 16'h8000;
    localparam logic [15:0] ID_RST     = 16'd1;

    typedef struct packed {
        logic        proxy_enabled;
        logic [31:0] primary_server;
        logic [31:0] secondary_server;
        logic [31:0] pending_timeout;
        logic [31:0] failover_timeout;
    } t_cfg;

    // per-slot lookup word
    typedef struct packed {
        logic        busy;
        logic [15:0] fwd_id;
        logic [31:0] start_time;
    } t_tag;

    // per-slot client details
    typedef struct packed {
        logic [15:0] client_id;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [47:0] src_mac;
        logic [15:0] vlan;
        logic [15:0] qtype;
    } t_slot_data;

endpackage

FILE: src/dnsrt_cfg_regs.sv
// APB register file of the DNS relay pending table.
// Depends on dnsrt_pkg for register indexes, reset values and t_cfg.
module dnsrt_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dnsrt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output dnsrt_pkg::t_cfg            o_cfg
);

    dnsrt_pkg::t_cfg r_cfg;
    logic [dnsrt_pkg::CFG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[dnsrt_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proxy_enabled    <= 1'b0;
            r_cfg.primary_server   <= '0;
            r_cfg.secondary_server <= '0;
            r_cfg.pending_timeout  <= dnsrt_pkg::TIMEOUT_RST;
            r_cfg.failover_timeout <= dnsrt_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                dnsrt_pkg::REG_PROXY_EN:    r_cfg.proxy_enabled    <= pwdata[0];
                dnsrt_pkg::REG_PRIMARY:     r_cfg.primary_server   <= pwdata;
                dnsrt_pkg::REG_SECONDARY:   r_cfg.secondary_server <= pwdata;
                dnsrt_pkg::REG_PEND_TMO:    r_cfg.pending_timeout  <= pwdata;
                dnsrt_pkg::REG_FAILOVR_TMO: r_cfg.failover_timeout <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dnsrt_pkg::REG_PROXY_EN:    prdata = {31'd0, r_cfg.proxy_enabled};
            dnsrt_pkg::REG_PRIMARY:     prdata = r_cfg.primary_server;
            dnsrt_pkg::REG_SECONDARY:   prdata = r_cfg.secondary_server;
            dnsrt_pkg::REG_PEND_TMO:    prdata = r_cfg.pending_timeout;
            dnsrt_pkg::REG_FAILOVR_TMO: prdata = r_cfg.failover_timeout;
            default:                    prdata = '0;
        endcase
    end

endmodule

FILE: src/dnsrt_slot_store.sv
// Slot memories of the DNS relay pending table: a tag array (busy, ID, start
// time) and a client detail array, each one write and one registered read port.
// Depends on dnsrt_pkg for t_tag and t_slot_data.
module dnsrt_slot_store #(
    parameter int SLOTS = dnsrt_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_tag_rd_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_tag_rd_addr,
    output dnsrt_pkg::t_tag                o_tag_rd_data,
    input  logic                           i_tag_wr_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_tag_wr_addr,
    input  dnsrt_pkg::t_tag                i_tag_wr_data,
    input  logic                           i_dat_rd_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_dat_rd_addr,
    output dnsrt_pkg::t_slot_data          o_dat_rd_data,
    input  logic                           i_dat_wr_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_dat_wr_addr,
    input  dnsrt_pkg::t_slot_data          i_dat_wr_data
);

    dnsrt_pkg::t_tag       r_tag_mem [SLOTS];
    dnsrt_pkg::t_slot_data r_dat_mem [SLOTS];
    dnsrt_pkg::t_tag       r_tag_rd;
    dnsrt_pkg::t_slot_data r_dat_rd;

    assign o_tag_rd_data = r_tag_rd;
    assign o_dat_rd_data = r_dat_rd;

    always_ff @(posedge i_clk) begin
        if (i_tag_wr_en) begin
            r_tag_mem[i_tag_wr_addr] <= i_tag_wr_data;
        end
        if (i_tag_rd_en) begin
            r_tag_rd <= r_tag_mem[i_tag_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dat_wr_en) begin
            r_dat_mem[i_dat_wr_addr] <= i_dat_wr_data;
        end
        if (i_dat_rd_en) begin
            r_dat_rd <= r_dat_mem[i_dat_rd_addr];
        end
    end

endmodule

FILE: src/dns_relay_pending_table_unit.sv
// Top level of the DNS relay pending table: item sequencer, failover state
// and output register. Depends on dnsrt_pkg, dnsrt_cfg_regs, dnsrt_slot_store.
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+-----------------------------
//   item in   | input     | i_in_valid / o_in_stall      | i_kind .. i_response_id
//   result    | output    | o_out_valid / i_out_stall    | o_status .. o_slot_query_type
//   config    | input     | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
// Query and response items scan the tag memory one slot per cycle, stopping at
// the first free or expired slot (query) or busy ID match (response).
// Check, disabled and no-uplink or no-server servfail items skip the scan; kind 3
// is dropped without a result. After reset a clearing pass marks every slot free,
// one slot per cycle; o_in_stall stays high meanwhile. A stalled result is held in
// the output register while the next item is accepted and worked on; that item
// then waits with its result until the register frees.
module dns_relay_pending_table_unit #(
    parameter int SLOTS = dnsrt_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item in
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_kind,
    input  logic [31:0]                  i_now,
    input  logic                         i_uplink_ready,
    input  logic [15:0]                  i_original_id,
    input  logic [31:0]                  i_src_ip,
    input  logic [15:0]                  i_src_port,
    input  logic [47:0]                  i_src_mac,
    input  logic [15:0]                  i_vlan_tag,
    input  logic [15:0]                  i_query_type,
    input  logic [15:0]                  i_response_id,
    // result out
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [15:0]                  o_fwd_id,
    output logic [15:0]                  o_upstream_port,
    output logic [31:0]                  o_server_ip,
    output logic [15:0]                  o_restored_id,
    output logic [31:0]                  o_dest_ip,
    output logic [15:0]                  o_dest_port,
    output logic [47:0]                  o_dest_mac,
    output logic [15:0]                  o_dest_vlan,
    output logic [15:0]                  o_slot_query_type,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dnsrt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    dnsrt_pkg::t_cfg cfg;

    // memory ports
    logic                  tag_rd_en;
    logic [IW-1:0]         tag_rd_addr;
    dnsrt_pkg::t_tag       tag_rd_data;
    logic                  tag_wr_en;
    logic [IW-1:0]         tag_wr_addr;
    dnsrt_pkg::t_tag       tag_wr_data;
    logic                  dat_rd_en;
    dnsrt_pkg::t_slot_data dat_rd_data;
    logic                  dat_wr_en;

    // control state
    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_chk_vld, n_chk_vld;
    logic [15:0]   r_next_id, n_next_id;
    logic          r_use_sec, n_use_sec;
    logic [31:0]   r_last_rsp, n_last_rsp;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [IW-1:0]         r_chk_idx, n_chk_idx;
    logic [1:0]            r_kind, n_kind;
    logic [31:0]           r_now, n_now;
    logic [15:0]           r_rid, n_rid;
    dnsrt_pkg::t_slot_data r_q, n_q;
    logic [2:0]            r_res_status, n_res_status;
    logic [15:0]           r_res_uid, n_res_uid;
    dnsrt_pkg::t_slot_data r_res_dat, n_res_dat;
    logic [2:0]            r_out_status, n_out_status;
    logic [15:0]           r_out_uid, n_out_uid;
    logic [15:0]           r_out_port, n_out_port;
    logic [31:0]           r_out_server, n_out_server;
    dnsrt_pkg::t_slot_data r_out_dat, n_out_dat;

    logic [31:0] active_server;
    logic        chk_expired;
    logic [15:0] id_inc;

    dnsrt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dnsrt_slot_store #(
        .SLOTS (SLOTS)
    ) u_slot_store (
        .i_clk         (i_clk),
        .i_tag_rd_en   (tag_rd_en),
        .i_tag_rd_addr (tag_rd_addr),
        .o_tag_rd_data (tag_rd_data),
        .i_tag_wr_en   (tag_wr_en),
        .i_tag_wr_addr (tag_wr_addr),
        .i_tag_wr_data (tag_wr_data),
        .i_dat_rd_en   (dat_rd_en),
        .i_dat_rd_addr (r_chk_idx),
        .o_dat_rd_data (dat_rd_data),
        .i_dat_wr_en   (dat_wr_en),
        .i_dat_wr_addr (r_chk_idx),
        .i_dat_wr_data (r_q)
    );

    assign active_server = r_use_sec ? cfg.secondary_server : cfg.primary_server;
    assign chk_expired   = (r_now - tag_rd_data.start_time) >= cfg.pending_timeout;
    assign id_inc        = r_next_id + 16'd1;
    assign o_in_stall    = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_issue_done = r_issue_done;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_next_id    = r_next_id;
        n_use_sec    = r_use_sec;
        n_last_rsp   = r_last_rsp;
        n_kind       = r_kind;
        n_now        = r_now;
        n_rid        = r_rid;
        n_q          = r_q;
        n_res_status = r_res_status;
        n_res_uid    = r_res_uid;
        n_res_dat    = r_res_dat;
        n_out_status = r_out_status;
        n_out_uid    = r_out_uid;
        n_out_port   = r_out_port;
        n_out_server = r_out_server;
        n_out_dat    = r_out_dat;
        n_out_valid  = r_out_valid && i_out_stall;

        tag_rd_en   = 1'b0;
        tag_rd_addr = r_rd_idx;
        tag_wr_en   = 1'b0;
        tag_wr_addr = r_chk_idx;
        tag_wr_data = '0;
        dat_rd_en   = 1'b0;
        dat_wr_en   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // mark one slot free per cycle
                tag_wr_en   = 1'b1;
                tag_wr_addr = r_rd_idx;
                n_rd_idx    = r_rd_idx + IW'(1);
                if (r_rd_idx == IDX_LAST) begin
                    n_rd_idx = '0;
                    n_state  = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind        = i_kind;
                    n_now         = i_now;
                    n_rid         = i_response_id;
                    n_q.client_id = i_original_id;
                    n_q.src_ip    = i_src_ip;
                    n_q.src_port  = i_src_port;
                    n_q.src_mac   = i_src_mac;
                    n_q.vlan      = i_vlan_tag;
                    n_q.qtype     = i_query_type;
                    n_res_uid     = '0;
                    n_res_dat     = '0;
                    n_rd_idx      = '0;
                    n_issue_done  = 1'b0;
                    case (i_kind)
                        dnsrt_pkg::KIND_QUERY: begin
                            if (!cfg.proxy_enabled) begin
                                n_res_status = dnsrt_pkg::ST_DISABLED;
                                n_state      = S_FIN;
                            end else if (!i_uplink_ready || active_server == '0) begin
                                n_res_status = dnsrt_pkg::ST_SERVFAIL;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        dnsrt_pkg::KIND_RESPONSE: begin
                            n_state = S_SCAN;
                        end
                        dnsrt_pkg::KIND_CHECK: begin
                            n_state = S_FIN;
                            if (!cfg.proxy_enabled) begin
                                n_res_status = dnsrt_pkg::ST_DISABLED;
                            end else if (cfg.secondary_server != '0 &&
                                         (i_now - r_last_rsp) >= cfg.failover_timeout) begin
                                n_use_sec    = !r_use_sec;
                                n_last_rsp   = i_now;
                                n_res_status = dnsrt_pkg::ST_SWITCHED;
                            end else begin
                                n_res_status = dnsrt_pkg::ST_NO_SWITCH;
                            end
                        end
                        default: begin
                            // unused kind: drop without a result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one tag read per cycle, check the word read last cycle
                if (!r_issue_done) begin
                    tag_rd_en = 1'b1;
                    n_rd_idx  = r_rd_idx + IW'(1);
                    if (r_rd_idx == IDX_LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
                n_chk_vld = tag_rd_en;
                n_chk_idx = r_rd_idx;
                if (r_chk_vld) begin
                    if (r_kind == dnsrt_pkg::KIND_QUERY) begin
                        if (!tag_rd_data.busy || chk_expired) begin
                            tag_wr_en              = 1'b1;
                            tag_wr_data.busy       = 1'b1;
                            tag_wr_data.fwd_id     = r_next_id;
                            tag_wr_data.start_time = r_now;
                            dat_wr_en              = 1'b1;
                            n_res_status = dnsrt_pkg::ST_FORWARDED;
                            n_res_uid    = r_next_id;
                            n_next_id    = (id_inc == '0) ? dnsrt_pkg::ID_RST : id_inc;
                            n_chk_vld    = 1'b0;
                            n_chk_idx    = r_chk_idx;
                            n_state      = S_FIN;
                        end else if (r_chk_idx == IDX_LAST) begin
                            n_res_status = dnsrt_pkg::ST_SERVFAIL;
                            n_chk_vld    = 1'b0;
                            n_state      = S_FIN;
                        end
                    end else begin
                        if (tag_rd_data.busy && tag_rd_data.fwd_id == r_rid) begin
                            // first ID match frees the slot either way
                            tag_wr_en = 1'b1;
                            n_chk_vld = 1'b0;
                            n_chk_idx = r_chk_idx;
                            if (chk_expired) begin
                                n_res_status = dnsrt_pkg::ST_UNKNOWN;
                                n_state      = S_FIN;
                            end else begin
                                dat_rd_en    = 1'b1;
                                n_res_status = dnsrt_pkg::ST_MATCHED;
                                n_res_uid    = r_rid;
                                n_last_rsp   = r_now;
                                n_state      = S_DATA;
                            end
                        end else if (r_chk_idx == IDX_LAST) begin
                            n_res_status = dnsrt_pkg::ST_UNKNOWN;
                            n_chk_vld    = 1'b0;
                            n_state      = S_FIN;
                        end
                    end
                end
            end

            S_DATA: begin
                n_res_dat = dat_rd_data;
                n_state   = S_FIN;
            end

            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_uid    = r_res_uid;
                    n_out_port   = (r_res_status == dnsrt_pkg::ST_FORWARDED) ?
                                   (r_res_uid | dnsrt_pkg::UPORT_FLAG) : '0;
                    n_out_server = active_server;
                    n_out_dat    = r_res_dat;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_rd_idx     <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_next_id    <= dnsrt_pkg::ID_RST;
            r_use_sec    <= 1'b0;
            r_last_rsp   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_idx     <= n_rd_idx;
            r_issue_done <= n_issue_done;
            r_chk_vld    <= n_chk_vld;
            r_next_id    <= n_next_id;
            r_use_sec    <= n_use_sec;
            r_last_rsp   <= n_last_rsp;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_kind       <= n_kind;
        r_now        <= n_now;
        r_rid        <= n_rid;
        r_q          <= n_q;
        r_res_status <= n_res_status;
        r_res_uid    <= n_res_uid;
        r_res_dat    <= n_res_dat;
        r_out_status <= n_out_status;
        r_out_uid    <= n_out_uid;
        r_out_port   <= n_out_port;
        r_out_server <= n_out_server;
        r_out_dat    <= n_out_dat;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_fwd_id          = r_out_uid;
    assign o_upstream_port   = r_out_port;
    assign o_server_ip       = r_out_server;
    assign o_restored_id     = r_out_dat.client_id;
    assign o_dest_ip         = r_out_dat.src_ip;
    assign o_dest_port       = r_out_dat.src_port;
    assign o_dest_mac        = r_out_dat.src_mac;
    assign o_dest_vlan       = r_out_dat.vlan;
    assign o_slot_query_type = r_out_dat.qtype;

endmodule
